/* hdl/mixed_waveform_phase_oscillator_macros.svh */
// Assertion macros shared by the oscillator modules.
`ifndef MIXED_WAVEFORM_PHASE_OSCILLATOR_MACROS_SVH
`define MIXED_WAVEFORM_PHASE_OSCILLATOR_MACROS_SVH

`ifndef SYNTH
`define MWPO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MWPO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MWPO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define MWPO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/mwpo_pkg.sv */
// Package with the constants, types and sine table of the oscillator.
package mwpo_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
  localparam int ROM_AW      = SINE_TABLE_BITS - 1;
  localparam int ROM_W       = FRAC_BITS + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 32;
  localparam int WEIGHT_W   = 16;
  localparam int OPCODE_W   = 2;

  localparam int WAVE_W    = FRAC_BITS + 2;
  localparam int MUL_B_W   = WEIGHT_W + 1;
  localparam int MIX_W     = WAVE_W + MUL_B_W + 2;
  localparam int LO_W      = MIX_W / 2;
  localparam int HI_W      = MIX_W - LO_W;
  localparam int MUL_A_W   = (WAVE_W > LO_W + 1) ? WAVE_W : LO_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int TOT_W     = MIX_W + MUL_B_W;
  localparam int ROUND_SH  = 30;
  localparam int Q_W       = TOT_W - ROUND_SH;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP      = 3'd0,
    REG_SINE_WEIGHT     = 3'd1,
    REG_TRIANGLE_WEIGHT = 3'd2,
    REG_SQUARE_WEIGHT   = 3'd3,
    REG_SAWTOOTH_WEIGHT = 3'd4,
    REG_OUTPUT_GAIN     = 3'd5
  } cfg_reg_e;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WAVE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_ACC,
    ST_GLO,
    ST_GHI,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MS_SINE,
    MS_TRI,
    MS_SQR,
    MS_SAW,
    MS_LO,
    MS_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    MIX_HOLD,
    MIX_LOAD,
    MIX_ADD
  } mix_op_e;

  typedef struct packed {
    logic [STEP_W-1:0]   phase_step;
    logic [WEIGHT_W-1:0] sine_weight;
    logic [WEIGHT_W-1:0] triangle_weight;
    logic [WEIGHT_W-1:0] square_weight;
    logic [WEIGHT_W-1:0] sawtooth_weight;
    logic [WEIGHT_W-1:0] output_gain;
  } cfg_t;

  typedef struct packed {
    logic     phase_start;
    logic     phase_clear;
    logic     wave_load;
    logic     mul_en;
    mul_sel_e mul_sel;
    mix_op_e  mix_op;
    logic     tot_load;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

  typedef logic [ROM_W-1:0] rom_t [QUARTER_LEN+1];

  // Quarter-wave sine by a Q30 Taylor series up to the thirteenth power.
  function automatic rom_t build_rom();
    rom_t               rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int i = 0; i <= QUARTER_LEN; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> (SINE_TABLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      rom[i] = ROM_W'((64'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Places a 32-bit cycle fraction on the accumulator's scale.
  function automatic logic [PHASE_BITS-1:0] align_phase(logic [STEP_W-1:0] v);
    logic [PHASE_BITS+STEP_W-1:0] w;
    w = {v, {PHASE_BITS{1'b0}}};
    return w[PHASE_BITS+STEP_W-1 -: PHASE_BITS];
  endfunction

endpackage

/* hdl/mwpo_regs.sv */
// Configuration register bank of the oscillator.
module mwpo_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mwpo_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mwpo_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output mwpo_pkg::cfg_t                   cfg_o
);
  import mwpo_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step      <= '0;
      cfg_q.sine_weight     <= WEIGHT_W'(32768);
      cfg_q.triangle_weight <= '0;
      cfg_q.square_weight   <= '0;
      cfg_q.sawtooth_weight <= '0;
      cfg_q.output_gain     <= WEIGHT_W'(32768);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PHASE_STEP:      cfg_q.phase_step      <= cfg_data_i[STEP_W-1:0];
        REG_SINE_WEIGHT:     cfg_q.sine_weight     <= cfg_data_i[WEIGHT_W-1:0];
        REG_TRIANGLE_WEIGHT: cfg_q.triangle_weight <= cfg_data_i[WEIGHT_W-1:0];
        REG_SQUARE_WEIGHT:   cfg_q.square_weight   <= cfg_data_i[WEIGHT_W-1:0];
        REG_SAWTOOTH_WEIGHT: cfg_q.sawtooth_weight <= cfg_data_i[WEIGHT_W-1:0];
        REG_OUTPUT_GAIN:     cfg_q.output_gain     <= cfg_data_i[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* hdl/mwpo_ctrl.sv */
// Sequencer that steps the datapath through one sample and handles start and stop.
`include "mixed_waveform_phase_oscillator_macros.svh"

module mwpo_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [mwpo_pkg::OPCODE_W-1:0]  in_opcode_i,
  output logic                           in_stall_o,
  input  mwpo_pkg::dp_status_t           status_i,
  output mwpo_pkg::dp_cmd_t              cmd_o
);
  import mwpo_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        playing_q, playing_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      playing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      playing_q <= playing_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    playing_d = playing_q;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_e'(in_opcode_i))
            OP_TICK: begin
              if (playing_q) begin
                state_d = ST_WAVE;
              end
            end
            OP_START: begin
              cmd_o.phase_start = 1'b1;
              playing_d         = 1'b1;
            end
            OP_STOP: begin
              cmd_o.phase_clear = 1'b1;
              playing_d         = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WAVE: begin
        cmd_o.wave_load = 1'b1;
        state_d         = ST_M0;
      end
      ST_M0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_SINE;
        state_d       = ST_M1;
      end
      ST_M1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_TRI;
        cmd_o.mix_op  = MIX_LOAD;
        state_d       = ST_M2;
      end
      ST_M2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_SQR;
        cmd_o.mix_op  = MIX_ADD;
        state_d       = ST_M3;
      end
      ST_M3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_SAW;
        cmd_o.mix_op  = MIX_ADD;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.mix_op = MIX_ADD;
        state_d      = ST_GLO;
      end
      ST_GLO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_LO;
        state_d       = ST_GHI;
      end
      ST_GHI: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MS_HI;
        cmd_o.tot_load = 1'b1;
        state_d        = ST_FIN;
      end
      ST_FIN: begin
        if (!status_i.out_blocked) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `MWPO_ASSERT_NEXT(a_tick_starts_sample, clk_i, rst_ni,
    in_valid_i && !in_stall_o && in_opcode_i == OP_TICK && playing_q,
    state_q == ST_WAVE, "tick while playing did not start a sample")
  `MWPO_ASSERT_NEXT(a_stop_clears_playing, clk_i, rst_ni,
    in_valid_i && !in_stall_o && in_opcode_i == OP_STOP,
    !playing_q && state_q == ST_IDLE, "stop item left the oscillator playing")
  `MWPO_ASSERT_SAME(a_finish_not_blocked, clk_i, rst_ni,
    cmd_o.finish, !status_i.out_blocked, "sample finished over an untaken result")

endmodule

/* hdl/mwpo_dp.sv */
// Datapath: phase accumulator, waveform generation, shared multiplier and output register.
`include "mixed_waveform_phase_oscillator_macros.svh"

module mwpo_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mwpo_pkg::dp_cmd_t                 cmd_i,
  input  mwpo_pkg::cfg_t                    cfg_i,
  input  logic [mwpo_pkg::STEP_W-1:0]       in_start_phase_i,
  input  logic                              out_stall_i,
  output mwpo_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  output logic signed [mwpo_pkg::SAMPLE_BITS-1:0] out_sample_o
);
  import mwpo_pkg::*;

  localparam logic [WAVE_W-1:0] ONE_WAVE   = WAVE_W'(1) << FRAC_BITS;
  localparam logic [WAVE_W-1:0] THREE_WAVE = ONE_WAVE + (ONE_WAVE << 1);
  localparam logic [ROM_AW-1:0] QUARTER_A  = ROM_AW'(QUARTER_LEN);
  localparam logic signed [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (ROUND_SH - 1);
  localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [Q_W-1:0] SAT_MIN = -(Q_W'(1) << FRAC_BITS);

  logic [PHASE_BITS-1:0]        phase_q;
  logic signed [WAVE_W-1:0]     sine_q, tri_q, sqr_q, saw_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [MIX_W-1:0]      mix_q;
  logic signed [TOT_W-1:0]      tot_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                         out_valid_q;

  logic [SINE_TABLE_BITS-1:0]   idx;
  logic [1:0]                   quad;
  logic [ROM_AW-1:0]            rom_addr;
  logic [ROM_W-1:0]             rom_val;
  logic [WAVE_W-1:0]            t;
  logic [WAVE_W-1:0]            sine_d, tri_d, sqr_d, saw_d;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]     prod_d;
  logic signed [TOT_W-1:0]      total;
  logic signed [Q_W-1:0]        q;
  logic signed [SAMPLE_BITS-1:0] sample_d;

  always_comb begin
    idx      = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad     = idx[SINE_TABLE_BITS-1 -: 2];
    rom_addr = quad[0] ? QUARTER_A - {1'b0, idx[SINE_TABLE_BITS-3:0]}
                       : {1'b0, idx[SINE_TABLE_BITS-3:0]};
    rom_val  = SINE_ROM[rom_addr];
    sine_d   = quad[1] ? -{1'b0, rom_val} : {1'b0, rom_val};
    t        = phase_q[PHASE_BITS-1 -: WAVE_W];
    tri_d    = t[WAVE_W-1] ? THREE_WAVE - t : t - ONE_WAVE;
    sqr_d    = phase_q[PHASE_BITS-1] ? -ONE_WAVE : ONE_WAVE;
    saw_d    = {1'b0, t[WAVE_W-1:1]} - ONE_WAVE;
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MS_SINE: begin
        mul_a = MUL_A_W'(sine_q);
        mul_b = $signed({1'b0, cfg_i.sine_weight});
      end
      MS_TRI: begin
        mul_a = MUL_A_W'(tri_q);
        mul_b = $signed({1'b0, cfg_i.triangle_weight});
      end
      MS_SQR: begin
        mul_a = MUL_A_W'(sqr_q);
        mul_b = $signed({1'b0, cfg_i.square_weight});
      end
      MS_SAW: begin
        mul_a = MUL_A_W'(saw_q);
        mul_b = $signed({1'b0, cfg_i.sawtooth_weight});
      end
      MS_LO: begin
        mul_a = $signed(MUL_A_W'({1'b0, mix_q[LO_W-1:0]}));
        mul_b = $signed({1'b0, cfg_i.output_gain});
      end
      MS_HI: begin
        mul_a = MUL_A_W'($signed(mix_q[MIX_W-1:LO_W]));
        mul_b = $signed({1'b0, cfg_i.output_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    total = tot_q + (TOT_W'(prod_q) <<< LO_W) + ROUND_HALF;
    q     = total[TOT_W-1:ROUND_SH];
    if (q > SAT_MAX) begin
      sample_d = SAMPLE_BITS'(SAT_MAX);
    end else if (q < SAT_MIN) begin
      sample_d = SAMPLE_BITS'(SAT_MIN);
    end else begin
      sample_d = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.phase_start) begin
        phase_q <= align_phase(in_start_phase_i);
      end else if (cmd_i.phase_clear) begin
        phase_q <= '0;
      end else if (cmd_i.finish) begin
        phase_q <= phase_q + align_phase(cfg_i.phase_step);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wave_load) begin
      sine_q <= sine_d;
      tri_q  <= tri_d;
      sqr_q  <= sqr_d;
      saw_q  <= saw_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    case (cmd_i.mix_op)
      MIX_LOAD: mix_q <= MIX_W'(prod_q);
      MIX_ADD:  mix_q <= mix_q + MIX_W'(prod_q);
      default: begin
      end
    endcase
    if (cmd_i.tot_load) begin
      tot_q <= TOT_W'(prod_q);
    end
    if (cmd_i.finish) begin
      sample_q <= sample_d;
    end
  end

  assign status_o.out_blocked = out_valid_q & out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_sample_o         = sample_q;

  `MWPO_ASSERT_NEXT(a_finish_shows_result, clk_i, rst_ni,
    cmd_i.finish, out_valid_o, "finished sample not presented")
  `MWPO_ASSERT_NEXT(a_stop_zeroes_phase, clk_i, rst_ni,
    cmd_i.phase_clear && !cmd_i.phase_start, phase_q == '0, "stop did not zero the phase")

endmodule

/* hdl/mixed_waveform_phase_oscillator.sv */
// Top level of the multi-waveform phase-accumulator oscillator.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   in_opcode_i, in_start_phase_i
//   out      output     out_valid_o / out_stall_i out_sample_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A tick item while playing holds off the next item while the sequencer loads the waves,
// forms the four mix products on the one shared 19 by 17 multiplier, accumulates, forms the
// two gain partial products on it and finishes, loading the sample into the output register.
// Start, stop and ignored items are taken without leaving the idle state.
// Reset loads the register defaults, zeroes the phase and stops playback; no clearing pass.
// A stalled result holds the sequencer in its last step until the result is taken.
module mixed_waveform_phase_oscillator (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [mwpo_pkg::OPCODE_W-1:0]           in_opcode_i,
  input  logic [mwpo_pkg::STEP_W-1:0]             in_start_phase_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [mwpo_pkg::SAMPLE_BITS-1:0] out_sample_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [mwpo_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [mwpo_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import mwpo_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  mwpo_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mwpo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_opcode_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mwpo_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .in_start_phase_i (in_start_phase_i),
    .out_stall_i      (out_stall_i),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_sample_o     (out_sample_o)
  );

endmodule

/* sim/mixed_waveform_phase_oscillator_tb.sv */
// Self-checking testbench for the mixed-waveform phase oscillator with a sample predictor.
module mixed_waveform_phase_oscillator_tb;
  import mwpo_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam longint FULL_SCALE = longint'(1) << FRAC_BITS;
  localparam longint unsigned HALF_PI_Q30_VAL = 64'd1686629713;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS = 10;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int NUM_SETTINGS = 10;
  localparam int ITEMS_PER_SETTING = 93;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [STEP_W-1:0]   start_phase;
  } osc_cmd_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic [OPCODE_W-1:0]           in_opcode = '0;
  logic [STEP_W-1:0]             in_start_phase = '0;
  logic                          out_stall = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic signed [SAMPLE_BITS-1:0] out_sample_o;
  logic                          cfg_ready_o;

  logic [SAMPLE_BITS-1:0]        quarter_sine [QUARTER_LEN+1];
  cfg_t                          osc_cfg = '{phase_step: '0, sine_weight: 16'd32768,
                                             triangle_weight: '0, square_weight: '0,
                                             sawtooth_weight: '0, output_gain: 16'd32768};
  logic [PHASE_BITS-1:0]         osc_phase = '0;
  logic                          osc_playing = 1'b0;

  osc_cmd_t                      pending_cmds [$];
  logic signed [SAMPLE_BITS-1:0] pending_samples [$];
  int                            items_in_flight = 0;
  int                            mismatches = 0;
  int                            gap_left = 0;
  int                            calm_items = 0;
  logic                          hold_for_drain = 1'b0;
  int                            stall_left = 0;

  mixed_waveform_phase_oscillator i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .in_opcode_i      (in_opcode),
    .in_start_phase_i (in_start_phase),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .out_sample_o     (out_sample_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [SAMPLE_BITS-1:0] mix_sample(logic [PHASE_BITS-1:0] ph);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-3:0] j;
    longint sine_v, tri_v, sqr_v, saw_v, tv;
    longint ws, wt, wq, wa, gain, mix, q;
    idx = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    j = idx[SINE_TABLE_BITS-3:0];
    sine_v = quad[0] ? longint'(quarter_sine[QUARTER_LEN - j]) : longint'(quarter_sine[j]);
    if (quad[1]) begin
      sine_v = -sine_v;
    end
    tv = longint'(ph >> (PHASE_BITS - FRAC_BITS - 2));
    tri_v = (tv < 2 * FULL_SCALE) ? tv - FULL_SCALE : 3 * FULL_SCALE - tv;
    sqr_v = ph[PHASE_BITS-1] ? -FULL_SCALE : FULL_SCALE;
    saw_v = (tv >>> 1) - FULL_SCALE;
    ws = longint'(osc_cfg.sine_weight);
    wt = longint'(osc_cfg.triangle_weight);
    wq = longint'(osc_cfg.square_weight);
    wa = longint'(osc_cfg.sawtooth_weight);
    gain = longint'(osc_cfg.output_gain);
    mix = ws * sine_v + wt * tri_v + wq * sqr_v + wa * saw_v;
    mix = mix * gain;
    q = (mix + (longint'(1) << 29)) >>> 30;
    if (q > FULL_SCALE - 1) begin
      q = FULL_SCALE - 1;
    end
    if (q < -FULL_SCALE) begin
      q = -FULL_SCALE;
    end
    return SAMPLE_BITS'(q);
  endfunction

  function automatic void advance_oscillator(logic [OPCODE_W-1:0] op, logic [STEP_W-1:0] ph);
    case (op)
      OP_START: begin
        osc_phase = ph;
        osc_playing = 1'b1;
      end
      OP_STOP: begin
        osc_playing = 1'b0;
        osc_phase = '0;
      end
      OP_TICK: begin
        if (osc_playing) begin
          pending_samples.push_back(mix_sample(osc_phase));
          osc_phase = osc_phase + osc_cfg.phase_step;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_cmd(logic [OPCODE_W-1:0] op, logic [STEP_W-1:0] ph);
    osc_cmd_t c;
    c.op = op;
    c.start_phase = ph;
    pending_cmds.push_back(c);
    items_in_flight++;
  endfunction

  function automatic void note_mismatch(string what, logic signed [SAMPLE_BITS-1:0] want,
                                        logic signed [SAMPLE_BITS-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [STEP_W-1:0] pick_phase();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return WEIGHT_W'($urandom());
    if (r < 20) return '0;
    if (r < 25) return 16'd32768;
    return WEIGHT_W'($urandom_range(0, 32768));
  endfunction

  function automatic cfg_t pick_setting(int n);
    cfg_t c;
    int   r;
    c.phase_step = '0;
    c.sine_weight = '0;
    c.triangle_weight = '0;
    c.square_weight = '0;
    c.sawtooth_weight = '0;
    c.output_gain = 16'd32768;
    case (n)
      1: begin
        c.phase_step = '1;
        c.triangle_weight = 16'd32768;
      end
      2: begin
        c.phase_step = $urandom();
        c.sine_weight = '1;
        c.triangle_weight = '1;
        c.square_weight = '1;
        c.sawtooth_weight = '1;
        c.output_gain = '1;
      end
      3: begin
        c.output_gain = '0;
      end
      4: begin
        c.phase_step = $urandom_range(1, 1 << 22);
        c.square_weight = 16'd32768;
        c.sawtooth_weight = 16'd32768;
      end
      default: begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          c.phase_step = $urandom_range(1, 1 << 24);
        end else if (r < 50) begin
          c.phase_step = pick_phase();
        end else begin
          c.phase_step = $urandom();
        end
        c.sine_weight = pick_weight();
        c.triangle_weight = pick_weight();
        c.square_weight = pick_weight();
        c.sawtooth_weight = pick_weight();
        c.output_gain = pick_weight();
      end
    endcase
    return c;
  endfunction

  task automatic put_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      REG_PHASE_STEP:      osc_cfg.phase_step = data[STEP_W-1:0];
      REG_SINE_WEIGHT:     osc_cfg.sine_weight = data[WEIGHT_W-1:0];
      REG_TRIANGLE_WEIGHT: osc_cfg.triangle_weight = data[WEIGHT_W-1:0];
      REG_SQUARE_WEIGHT:   osc_cfg.square_weight = data[WEIGHT_W-1:0];
      REG_SAWTOOTH_WEIGHT: osc_cfg.sawtooth_weight = data[WEIGHT_W-1:0];
      REG_OUTPUT_GAIN:     osc_cfg.output_gain = data[WEIGHT_W-1:0];
      default: begin
      end
    endcase
  endtask

  // The upper data bits of the 16-bit registers carry noise that must be dropped.
  task automatic write_setting(cfg_t c);
    put_reg(REG_PHASE_STEP, c.phase_step);
    put_reg(REG_SINE_WEIGHT, {16'($urandom()), c.sine_weight});
    put_reg(REG_TRIANGLE_WEIGHT, {16'($urandom()), c.triangle_weight});
    put_reg(REG_SQUARE_WEIGHT, {16'($urandom()), c.square_weight});
    put_reg(REG_SAWTOOTH_WEIGHT, {16'($urandom()), c.sawtooth_weight});
    put_reg(REG_OUTPUT_GAIN, {16'($urandom()), c.output_gain});
    cfg_valid <= 1'b0;
  endtask

  task automatic await_idle();
    @(posedge clk);
    while (items_in_flight != 0 || pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly start-and-tick runs; ticks while stopped and the unused opcode are thrown in.
  task automatic queue_random_cmds(int count);
    int   made;
    int   r;
    logic running;
    made = 0;
    running = osc_playing;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (!running) begin
        if (r < 85) begin
          queue_cmd(OP_START, pick_phase());
          running = 1'b1;
          made++;
        end else if (r < 92) begin
          queue_cmd(OP_TICK, $urandom());
        end else if (r < 96) begin
          queue_cmd(OP_STOP, $urandom());
          made++;
        end else begin
          queue_cmd(OP_UNUSED, $urandom());
        end
      end else begin
        if (r < 80) begin
          queue_cmd(OP_TICK, $urandom());
          made++;
        end else if (r < 88) begin
          queue_cmd(OP_START, pick_phase());
          made++;
        end else if (r < 95) begin
          queue_cmd(OP_STOP, $urandom());
          running = 1'b0;
          made++;
        end else begin
          queue_cmd(OP_UNUSED, $urandom());
        end
      end
    end
  endtask

  always @(posedge clk) begin : drive_items
    osc_cmd_t c;
    if (rst_n) begin
      if (in_valid && !in_stall_o) begin
        advance_oscillator(in_opcode, in_start_phase);
        items_in_flight--;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (hold_for_drain && pending_samples.size() != 0) begin
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_opcode <= c.op;
          in_start_phase <= c.start_phase;
          gap_left <= (calm_items > 0) ? 0 : next_gap();
          if (calm_items > 0) begin
            calm_items <= calm_items - 1;
          end else if ($urandom_range(0, 39) == 0) begin
            calm_items <= $urandom_range(20, 50);
          end
          hold_for_drain <= ($urandom_range(0, 59) == 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_samples
    logic signed [SAMPLE_BITS-1:0] want;
    int                            r;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (pending_samples.size() == 0) begin
          note_mismatch("sample with nothing pending", '0, out_sample_o);
        end else begin
          want = pending_samples.pop_front();
          if (out_sample_o !== want) begin
            note_mismatch("sample mismatch", want, out_sample_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(0, 6);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(0, 3);
        end else if (r < 97) begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(10, 40);
        end else begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(100, 300);
        end
      end
    end
  end

  initial begin : run_test
    longint unsigned x, x2, term;
    longint          sum;
    logic [STEP_W-1:0] corners [8];
    for (int i = 0; i <= QUARTER_LEN; i++) begin
      x = (HALF_PI_Q30_VAL * i) >> (SINE_TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      quarter_sine[i] = SAMPLE_BITS'((sum + (longint'(1) << (29 - FRAC_BITS))) >>>
                                     (30 - FRAC_BITS));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: pure sine at unity gain with a zero step, so each tick shows its start phase.
    corners = '{32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hBFFF_FFFF,
                32'hC000_0000, 32'hFFFF_FFFF, 32'h0040_0000, 32'h3FC0_0000};
    queue_cmd(OP_TICK, '0);
    queue_cmd(OP_UNUSED, '1);
    queue_cmd(OP_STOP, '1);
    queue_cmd(OP_START, '0);
    queue_cmd(OP_TICK, '1);
    foreach (corners[i]) begin
      queue_cmd(OP_START, corners[i]);
      queue_cmd(OP_TICK, '0);
    end
    queue_cmd(OP_UNUSED, '0);
    queue_cmd(OP_TICK, '0);
    queue_cmd(OP_STOP, '0);
    queue_cmd(OP_TICK, '0);
    await_idle();

    for (int n = 1; n <= NUM_SETTINGS; n++) begin
      write_setting(pick_setting(n));
      queue_random_cmds(ITEMS_PER_SETTING);
      await_idle();
    end

    if (pending_samples.size() != 0) begin
      mismatches += pending_samples.size();
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/mwpo_pkg.sv
hdl/mwpo_regs.sv
hdl/mwpo_ctrl.sv
hdl/mwpo_dp.sv
hdl/mixed_waveform_phase_oscillator.sv
sim/mixed_waveform_phase_oscillator_tb.sv
